// ===== src/llms_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, register indexes and controller/datapath interface structs
// for the leaky lms noise filter; no dependencies

package llms_pkg;

    // payload and register widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 32;
    localparam int DELAY_W    = 9;
    localparam int STEP_W     = 16;
    localparam int LEAK_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // register reset values
    localparam logic               MODE_RST  = 1'b0;
    localparam logic [DELAY_W-1:0] DELAY_RST = 9'd48;
    localparam logic [STEP_W-1:0]  STEP_RST  = 16'd8192;
    localparam logic [LEAK_W-1:0]  LEAK_RST  = 17'd65480;

    // fixed point alignment shifts
    localparam int X_ALIGN_SH = 29;  // sample to 2^-44 units
    localparam int ERR_OUT_SH = 29;  // error to output sample
    localparam int FIR_OUT_SH = 28;  // twice the estimate to output sample
    localparam int ERR_Q_SH   = 15;  // error to 2^-29 units
    localparam int STEP_SH    = 16;  // beta scaling
    localparam int COEF_SH    = 16;  // new coefficient to 2^-29 units

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE  = 2'd0,
        REG_DELAY = 2'd1,
        REG_STEP  = 2'd2,
        REG_LEAK  = 2'd3
    } t_reg_idx;

    // controller to datapath
    typedef struct packed {
        logic clear_restart;
        logic clear_run;
        logic accept;
        logic tap_issue;
        logic phase_upd;
        logic err_s1;
        logic err_s2;
        logic err_s3;
        logic err_s4;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic tap_last;
        logic pipe_busy;
    } t_status;

endpackage

// ===== src/llms_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer for the leaky lms noise filter: clearing pass, fir sweep,
// error steps, coefficient update sweep and output handoff; uses llms_pkg

module llms_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  llms_pkg::t_status  i_status,
    output llms_pkg::t_cmd     o_cmd
);
    import llms_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_FIR    = 11'b000_0000_0100,
        S_FDRAIN = 11'b000_0000_1000,
        S_E1     = 11'b000_0001_0000,
        S_E2     = 11'b000_0010_0000,
        S_E3     = 11'b000_0100_0000,
        S_E4     = 11'b000_1000_0000,
        S_UPD    = 11'b001_0000_0000,
        S_UDRAIN = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign slot_free   = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (i_status.clear_last) n_state = S_IDLE;
            S_IDLE:   if (accept) n_state = S_FIR;
            S_FIR:    if (i_status.tap_last) n_state = S_FDRAIN;
            S_FDRAIN: if (!i_status.pipe_busy) n_state = S_E1;
            S_E1:     n_state = S_E2;
            S_E2:     n_state = S_E3;
            S_E3:     n_state = S_E4;
            S_E4:     n_state = S_UPD;
            S_UPD:    if (i_status.tap_last) n_state = S_UDRAIN;
            S_UDRAIN: if (!i_status.pipe_busy) n_state = S_DONE;
            S_DONE:   if (slot_free) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
        // a register write restarts the clearing pass
        if (i_cfg_we) n_state = S_CLEAR;
    end

    // commands
    always_comb begin
        o_cmd               = '0;
        o_cmd.clear_restart = i_cfg_we;
        o_cmd.clear_run     = (r_state == S_CLEAR);
        o_cmd.accept        = accept;
        o_cmd.tap_issue     = (r_state == S_FIR) || (r_state == S_UPD);
        o_cmd.phase_upd     = (r_state == S_UPD) || (r_state == S_UDRAIN);
        o_cmd.err_s1        = (r_state == S_E1);
        o_cmd.err_s2        = (r_state == S_E2);
        o_cmd.err_s3        = (r_state == S_E3);
        o_cmd.err_s4        = (r_state == S_E4);
        o_cmd.out_load      = (r_state == S_DONE) && slot_free;
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (o_cmd.out_load) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/llms_datapath.sv =====
`timescale 1ns / 1ps
// datapath of the leaky lms noise filter: registers, sample ring and weight
// memories, tap pipeline, error chain and output register; uses llms_pkg

module llms_datapath #(
    parameter int TAPS      = 64,
    parameter int MAX_DELAY = 300
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [llms_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [llms_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic signed [llms_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic                                  i_block_end,
    output logic signed [llms_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                  o_last_out,
    input  llms_pkg::t_cmd                        i_cmd,
    output llms_pkg::t_status                     o_status
);
    import llms_pkg::*;

    localparam int RING_DEPTH = MAX_DELAY + TAPS;
    localparam int RA    = $clog2(RING_DEPTH);
    localparam int LW    = $clog2(RING_DEPTH + 1);
    localparam int TA    = $clog2(TAPS);
    localparam int ACC_W = SAMPLE_W + COEF_W + TA;
    localparam int ERR_W = ACC_W + 1;
    localparam int EQ_W  = ERR_W + 1 - ERR_Q_SH;
    localparam int EP_W  = EQ_W + STEP_W + 1;
    localparam int E2_W  = EQ_W + 1;
    localparam int PA_W  = SAMPLE_W + E2_W;
    localparam int PB_W  = COEF_W + LEAK_W + 1;
    localparam int NC_W  = PA_W + 2;
    localparam int SH_W  = NC_W - COEF_SH;

    // configuration registers
    logic               r_mode;
    logic [DELAY_W-1:0] r_delay;
    logic [STEP_W-1:0]  r_step;
    logic [LEAK_W-1:0]  r_leak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_RST;
            r_delay <= DELAY_RST;
            r_step  <= STEP_RST;
            r_leak  <= LEAK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:  r_mode  <= i_cfg_wdata[0];
                REG_DELAY: r_delay <= i_cfg_wdata[DELAY_W-1:0];
                REG_STEP:  r_step  <= i_cfg_wdata[STEP_W-1:0];
                REG_LEAK:  r_leak  <= i_cfg_wdata[LEAK_W-1:0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    // effective ring length, delay clamped to the maximum
    localparam int DW = (DELAY_W > LW) ? DELAY_W : LW;
    logic [DW-1:0] delay_ext;
    logic [LW-1:0] delay_eff;
    logic [LW-1:0] ring_len;

    assign delay_ext = DW'(r_delay);
    assign delay_eff = (delay_ext > DW'(MAX_DELAY)) ? LW'(MAX_DELAY) : LW'(delay_ext);
    assign ring_len  = delay_eff + LW'(TAPS);

    function automatic logic [RA-1:0] ring_next(input logic [RA-1:0] p,
                                                input logic [LW-1:0] len);
        logic [LW:0] inc;
        begin
            inc = {1'b0, LW'(p)} + (LW + 1)'(1);
            ring_next = (inc >= {1'b0, len}) ? '0 : inc[RA-1:0];
        end
    endfunction

    // clearing pass counter
    logic [RA-1:0] r_clr_cnt;
    logic          clr_last;

    assign clr_last = (r_clr_cnt == RA'(RING_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_restart) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear_run && !clr_last) begin
            r_clr_cnt <= r_clr_cnt + RA'(1);
        end
    end

    // ring pointer, read pointer and tap counter
    logic [RA-1:0] r_ptr;
    logic [RA-1:0] r_rd;
    logic [TA-1:0] r_tap;
    logic [RA-1:0] wp;
    logic [RA-1:0] wp_next;

    assign wp      = (LW'(r_ptr) < ring_len) ? r_ptr : '0;
    assign wp_next = ring_next(wp, ring_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_restart) begin
            r_ptr <= '0;
            r_rd  <= '0;
            r_tap <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_ptr <= wp_next;
                r_rd  <= wp_next;
                r_tap <= '0;
            end else if (i_cmd.err_s4) begin
                r_rd  <= r_ptr;
                r_tap <= '0;
            end else if (i_cmd.tap_issue) begin
                r_rd  <= ring_next(r_rd, ring_len);
                r_tap <= r_tap + TA'(1);
            end
        end
    end

    // captured input transaction
    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_blk;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x   <= i_sample_in;
            r_blk <= i_block_end;
        end
    end

    // sample ring memory
    logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic signed [SAMPLE_W-1:0] r_ring_rd;
    logic                       ring_we;
    logic [RA-1:0]              ring_wa;
    logic signed [SAMPLE_W-1:0] ring_wd;

    assign ring_we = i_cmd.clear_run || i_cmd.accept;
    assign ring_wa = i_cmd.clear_run ? r_clr_cnt : wp;
    assign ring_wd = i_cmd.clear_run ? '0 : i_sample_in;

    always_ff @(posedge i_clk) begin
        if (ring_we) ring_mem[ring_wa] <= ring_wd;
        r_ring_rd <= ring_mem[r_rd];
    end

    // weight memory
    logic signed [COEF_W-1:0] wt_mem [TAPS];
    logic signed [COEF_W-1:0] r_wt_rd;
    logic                     wt_we;
    logic [TA-1:0]            wt_wa;
    logic signed [COEF_W-1:0] wt_wd;
    logic [TA-1:0]            r_tap1, r_tap2;
    logic                     r_v1, r_v2;
    logic signed [COEF_W-1:0] coef_new;

    assign wt_we = (i_cmd.clear_run && (r_clr_cnt < RA'(TAPS)))
                || (r_v2 && i_cmd.phase_upd);
    assign wt_wa = i_cmd.clear_run ? r_clr_cnt[TA-1:0] : r_tap2;
    assign wt_wd = i_cmd.clear_run ? '0 : coef_new;

    always_ff @(posedge i_clk) begin
        if (wt_we) wt_mem[wt_wa] <= wt_wd;
        r_wt_rd <= wt_mem[r_tap];
    end

    // tap pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_restart) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.tap_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tap1 <= r_tap;
        r_tap2 <= r_tap1;
    end

    // multipliers: sample times weight or scaled error, weight times leak
    logic signed [E2_W-1:0]   r_err2;
    logic signed [E2_W-1:0]   op_b;
    logic signed [PA_W-1:0]   r_pa;
    logic signed [PB_W-1:0]   r_pb;
    logic signed [LEAK_W:0]   leak_s;

    assign op_b   = i_cmd.phase_upd ? r_err2
                  : {{(E2_W - COEF_W){r_wt_rd[COEF_W-1]}}, r_wt_rd};
    assign leak_s = $signed({1'b0, r_leak});

    always_ff @(posedge i_clk) begin
        r_pa <= r_ring_rd * op_b;
        r_pb <= r_wt_rd * leak_s;
    end

    // fir accumulator
    logic signed [ACC_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_acc <= '0;
        end else if (r_v2 && !i_cmd.phase_upd) begin
            r_acc <= r_acc + r_pa[ACC_W-1:0];
        end
    end

    // coefficient update: round to nearest, ties away, then saturate
    logic signed [NC_W-1:0] nc_sum;
    logic signed [NC_W-1:0] nc_rnd;
    logic signed [NC_W-1:0] nc_sh;

    always_comb begin
        nc_sum = ({{2{r_pa[PA_W-1]}}, r_pa} <<< 1)
               + {{(NC_W - PB_W){r_pb[PB_W-1]}}, r_pb};
        nc_rnd = nc_sum + NC_W'(2 ** (COEF_SH - 1)) - NC_W'(nc_sum[NC_W-1]);
        nc_sh  = nc_rnd >>> COEF_SH;
        if ((&nc_sh[SH_W-1:COEF_W-1]) || !(|nc_sh[SH_W-1:COEF_W-1])) begin
            coef_new = nc_sh[COEF_W-1:0];
        end else begin
            coef_new = {nc_sh[SH_W-1], {(COEF_W - 1){~nc_sh[SH_W-1]}}};
        end
    end

    // error chain
    logic signed [ERR_W-1:0] r_err;
    logic signed [EQ_W-1:0]  r_err_q;
    logic signed [EP_W-1:0]  r_eprod;
    logic signed [SAMPLE_W-1:0] r_res;

    logic signed [ERR_W:0]   e29_rnd, e29_sh;
    logic signed [ERR_W:0]   e15_rnd, e15_sh;
    logic signed [ACC_W:0]   a28_rnd, a28_sh;
    logic signed [EP_W:0]    p16_rnd, p16_sh;
    logic signed [ERR_W:0]   res_wide;
    logic signed [SAMPLE_W-1:0] res_sat;

    always_comb begin
        e29_rnd = {r_err[ERR_W-1], r_err} + (ERR_W + 1)'(2 ** (ERR_OUT_SH - 1))
                - (ERR_W + 1)'(r_err[ERR_W-1]);
        e29_sh  = e29_rnd >>> ERR_OUT_SH;
        e15_rnd = {r_err[ERR_W-1], r_err} + (ERR_W + 1)'(2 ** (ERR_Q_SH - 1))
                - (ERR_W + 1)'(r_err[ERR_W-1]);
        e15_sh  = e15_rnd >>> ERR_Q_SH;
        a28_rnd = {r_acc[ACC_W-1], r_acc} + (ACC_W + 1)'(2 ** (FIR_OUT_SH - 1))
                - (ACC_W + 1)'(r_acc[ACC_W-1]);
        a28_sh  = a28_rnd >>> FIR_OUT_SH;
        p16_rnd = {r_eprod[EP_W-1], r_eprod} + (EP_W + 1)'(2 ** (STEP_SH - 1))
                - (EP_W + 1)'(r_eprod[EP_W-1]);
        p16_sh  = p16_rnd >>> STEP_SH;

        // output selection and saturation to 16 bits
        res_wide = r_mode ? {a28_sh[ACC_W], a28_sh} : e29_sh;
        if ((&res_wide[ERR_W:SAMPLE_W-1]) || !(|res_wide[ERR_W:SAMPLE_W-1])) begin
            res_sat = res_wide[SAMPLE_W-1:0];
        end else begin
            res_sat = {res_wide[ERR_W], {(SAMPLE_W - 1){~res_wide[ERR_W]}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err_s1) begin
            r_err <= ({{(ERR_W - SAMPLE_W){r_x[SAMPLE_W-1]}}, r_x} <<< X_ALIGN_SH)
                   - {r_acc[ACC_W-1], r_acc};
        end
        if (i_cmd.err_s2) begin
            r_err_q <= e15_sh[EQ_W-1:0];
            r_res   <= res_sat;
        end
        if (i_cmd.err_s3) begin
            r_eprod <= r_err_q * $signed({1'b0, r_step});
        end
        if (i_cmd.err_s4) begin
            r_err2 <= p16_sh[E2_W-1:0];
        end
    end

    // output register
    logic signed [SAMPLE_W-1:0] r_sample_out;
    logic                       r_last_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_sample_out <= r_res;
            r_last_out   <= r_blk;
        end
    end

    assign o_sample_out = r_sample_out;
    assign o_last_out   = r_last_out;

    // status
    assign o_status.clear_last = clr_last;
    assign o_status.tap_last   = (r_tap == TA'(TAPS - 1));
    assign o_status.pipe_busy  = r_v1 || r_v2;

endmodule

// ===== src/leaky_lms_noise_filter.sv =====
`timescale 1ns / 1ps
// top level of the leaky lms noise filter: controller plus datapath
// depends on llms_pkg, llms_ctrl and llms_datapath

// Leaky LMS adaptive filter for audio, autonotch (error out) or denoise (twice
// the estimate out). One sample is processed at a time: the tap loop runs on
// one shared multiply-accumulate pipeline, once for the FIR sum and once for
// the coefficient update. The next sample can be taken from the cycle in
// which the result becomes valid, and the result register lets a new sample
// enter while the previous result still waits. After reset and after every
// register write the sample ring and the weights are cleared by a pass over
// all MAX_DELAY+TAPS ring entries, during which no sample is taken; register
// writes are accepted at any time but belong in idle periods.

module leaky_lms_noise_filter #(
    parameter int TAPS      = 64,
    parameter int MAX_DELAY = 300
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [llms_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [llms_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [llms_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic                                  i_block_end,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [llms_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                  o_last_out
);
    import llms_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer
    llms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // arithmetic and storage
    llms_datapath #(
        .TAPS      (TAPS),
        .MAX_DELAY (MAX_DELAY)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample_in  (i_sample_in),
        .i_block_end  (i_block_end),
        .o_sample_out (o_sample_out),
        .o_last_out   (o_last_out),
        .i_cmd        (cmd),
        .o_status     (status)
    );

endmodule
